// ===== design/chm_pkg.sv =====
// chm_pkg: shared types and constants for the chained hash map
// controller state encoding, command and status bundles
// no dependencies
`timescale 1ns / 1ps

package chm_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CFG_W      = 7;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = KEY_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_HEAD,
		ST_LINK,
		ST_WALK,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic fix;
		logic head_rd;
		logic link;
		logic node_rd;
		logic advance;
		logic set_hit;
		logic set_miss;
		logic set_full;
		logic insert;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic ptr_ok;
		logic key_match;
		logic pool_full;
		logic op_look;
		logic out_free;
	} sts_t;

endpackage

// ===== design/chm_ctrl.sv =====
// chm_ctrl: request sequencer for the chained hash map
// drives datapath commands from its status; uses chm_pkg
`timescale 1ns / 1ps

module chm_ctrl import chm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nx = ST_DIV;
			ST_DIV:  if (sts.div_last) state_nx = ST_FIX;
			ST_FIX:  state_nx = ST_HEAD;
			ST_HEAD: state_nx = ST_LINK;
			ST_LINK: state_nx = ST_WALK;
			ST_WALK: state_nx = sts.ptr_ok ? ST_CMP : ST_DONE;
			ST_CMP:  state_nx = sts.key_match ? ST_DONE : ST_WALK;
			ST_DONE: if (sts.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FIX:  cmd.fix = 1'b1;
			ST_HEAD: cmd.head_rd = 1'b1;
			ST_LINK: cmd.link = 1'b1;
			ST_WALK: begin
				priority if (sts.ptr_ok) cmd.node_rd = 1'b1;
				else if (sts.op_look) cmd.set_miss = 1'b1;
				else if (sts.pool_full) cmd.set_full = 1'b1;
				else cmd.insert = 1'b1;
			end
			ST_CMP: begin
				if (sts.key_match) cmd.set_hit = 1'b1;
				else cmd.advance = 1'b1;
			end
			ST_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/chm_dp.sv =====
// chm_dp: datapath of the chained hash map
// remainder unit, bucket head and node memories, result registers; uses chm_pkg
`timescale 1ns / 1ps

module chm_dp import chm_pkg::*; #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [0:0]       s_tuser,
	input  logic [63:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,
	output logic [2:0]       m_tuser,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int HEADS = (BUCKETS < (1 << CFG_W)) ? BUCKETS : (1 << CFG_W);
	localparam int HB    = (HEADS > 1) ? $clog2(HEADS) : 1;
	localparam int NB    = $clog2(NODES);

	logic [CFG_W-1:0] num_buckets_q;
	logic [CFG_W-1:0] eff;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [KEY_W-1:0] dvd_q;
	logic             neg_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] rem_nx;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HB-1:0]    bucket_q;
	logic [NB-1:0]    ptr_q;
	logic             ok_q;
	logic [NB-1:0]    hptr_q;
	logic             hok_q;
	logic [NB:0]      used_q;
	logic [HEADS-1:0] hvalid_q;

	logic [NB-1:0]    head_mem [HEADS];
	logic [KEY_W-1:0] key_mem  [NODES];
	logic [VAL_W-1:0] val_mem  [NODES];
	logic [NB:0]      link_mem [NODES];
	logic [NB-1:0]    head_rd;
	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;
	logic [NB:0]      link_rd;

	logic             res_found_q, res_ins_q, res_full_q;
	logic [VAL_W-1:0] res_val_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;
	logic [2:0]       out_user_q;

	always_comb begin
		if (num_buckets_q == '0) eff = CFG_W'(1);
		else if (32'(num_buckets_q) > BUCKETS) eff = CFG_W'(BUCKETS);
		else eff = num_buckets_q;
	end

	// four dividend bits per cycle, msb first
	always_comb begin
		logic [CFG_W:0] t;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_nx, dvd_q[KEY_W-1-i]};
			if (t >= {1'b0, eff}) t = t - {1'b0, eff};
			rem_nx = t[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q <= CFG_W'(BUCKETS);
			used_q        <= '0;
			hvalid_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) num_buckets_q <= cfg_data;
			if (cmd.insert) begin
				used_q             <= used_q + 1'b1;
				hvalid_q[bucket_q] <= 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser[0];
			key_q <= s_tdata[31:0];
			val_q <= s_tdata[63:32];
			neg_q <= s_tdata[31];
			dvd_q <= s_tdata[31] ? (~s_tdata[31:0] + 1'b1) : s_tdata[31:0];
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << DIV_BITS;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.fix) begin
			bucket_q <= HB'((neg_q && rem_q != '0) ? (eff - rem_q) : rem_q);
		end
		if (cmd.link) begin
			ptr_q  <= head_rd;
			ok_q   <= hvalid_q[bucket_q];
			hptr_q <= head_rd;
			hok_q  <= hvalid_q[bucket_q];
		end
		if (cmd.advance) begin
			ptr_q <= link_rd[NB-1:0];
			ok_q  <= link_rd[NB];
		end
		if (cmd.set_hit) begin
			res_found_q <= 1'b1;
			res_val_q   <= val_rd;
			res_ins_q   <= 1'b0;
			res_full_q  <= 1'b0;
		end
		if (cmd.set_miss || cmd.set_full || cmd.insert) begin
			res_found_q <= 1'b0;
			res_val_q   <= '0;
			res_ins_q   <= cmd.insert;
			res_full_q  <= cmd.set_full;
		end
		if (cmd.out_load) begin
			out_data_q <= res_val_q;
			out_user_q <= {res_full_q, res_ins_q, res_found_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) head_mem[bucket_q] <= used_q[NB-1:0];
		if (cmd.head_rd) head_rd <= head_mem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_mem[used_q[NB-1:0]]  <= key_q;
			val_mem[used_q[NB-1:0]]  <= val_q;
			link_mem[used_q[NB-1:0]] <= {hok_q, hptr_q};
		end
		if (cmd.node_rd) begin
			key_rd  <= key_mem[ptr_q];
			val_rd  <= val_mem[ptr_q];
			link_rd <= link_mem[ptr_q];
		end
	end

	always_comb begin
		sts.div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		sts.ptr_ok    = ok_q;
		sts.key_match = (key_rd == key_q);
		sts.pool_full = (used_q == (NB + 1)'(NODES));
		sts.op_look   = op_q;
		sts.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ===== design/chained_hash_map.sv =====
// chained_hash_map: top level of the integer-keyed chained hash map
// joins chm_ctrl and chm_dp; uses chm_pkg
//
// channel  dir  signals                      payload
// s        in   s_tvalid s_tready s_tdata    tdata key[31:0] value[63:32], tuser op
// m        out  m_tvalid m_tready m_tdata    tdata value_out, tuser found/inserted/full_res
// cfg      in   cfg_valid cfg_ready cfg_data num_buckets
//
// one request at a time: remainder steps (4 bits a cycle) in ST_DIV, a sign fix in ST_FIX,
// the head read in ST_HEAD and ST_LINK, a node read and compare per chain node in ST_WALK
// and ST_CMP, ST_WALK closing a miss, and ST_DONE loading the result, then back to ST_IDLE
// the chain walk reads one node at a time from the node memory
// reset clears bucket head valid bits and the pool count at once, no sweep
// a result waiting on m_tready does not block acceptance of the next request
`timescale 1ns / 1ps

module chained_hash_map import chm_pkg::*; #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,  // key, value
	input  logic [0:0]       s_tuser,  // op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,  // value_out
	output logic [2:0]       m_tuser   // found, inserted, full_res
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	chm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chm_dp #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== design/chm_checker.sv =====
// chm_checker: port-level checks for chained_hash_map, bound to the top level
// depends on chained_hash_map ports only
`timescale 1ns / 1ps

module chm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tuser) <= 1)
		else $error("more than one result flag set");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("value given without a hit");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

endmodule

bind chained_hash_map chm_checker u_chm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/chm_checker.sv =====
// chm_scoreboard: watches the request, result and config channels of chained_hash_map
// keeps its own copy of the table, predicts each result and compares field by field
// depends on chm_pkg
`timescale 1ns / 1ps

module chm_scoreboard import chm_pkg::*; #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [63:0]      s_tdata,
	input  logic [0:0]       s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [31:0]      m_tdata,
	input  logic [2:0]       m_tuser,
	output int               fail_count,
	output int               pending,
	output int               results_seen
);

	localparam logic OP_INSERT = 1'b0;

	typedef struct {
		logic        found;
		logic [31:0] value_out;
		logic        inserted;
		logic        full_res;
	} lookup_res_t;

	lookup_res_t res_q[$];
	int          head_idx[BUCKETS];
	logic [31:0] pool_key[NODES];
	logic [31:0] pool_val[NODES];
	int          pool_next[NODES];
	int          used;
	logic [6:0]  bucket_cfg;

	function automatic int bucket_index(logic [31:0] key);
		longint n;
		longint r;
		n = (bucket_cfg == 0) ? 1 : ((bucket_cfg > BUCKETS) ? BUCKETS : bucket_cfg);
		r = longint'(signed'(key)) % n;
		if (r < 0)
			r += n;
		return int'(r);
	endfunction

	function automatic lookup_res_t table_access(logic op, logic [31:0] key, logic [31:0] val);
		lookup_res_t r;
		int b;
		int p;
		int steps;
		r = '{1'b0, 32'd0, 1'b0, 1'b0};
		b = bucket_index(key);
		p = head_idx[b];
		steps = 0;
		while (p >= 0 && steps < used) begin
			if (pool_key[p] == key) begin
				r.found = 1'b1;
				r.value_out = pool_val[p];
				break;
			end
			p = pool_next[p];
			steps++;
		end
		if (op == OP_INSERT && !r.found) begin
			if (used < NODES) begin
				pool_key[used] = key;
				pool_val[used] = val;
				pool_next[used] = head_idx[b];
				head_idx[b] = used;
				used++;
				r.inserted = 1'b1;
			end else begin
				r.full_res = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t e;
		if (!arst_n) begin
			res_q.delete();
			foreach (head_idx[i])
				head_idx[i] = -1;
			used = 0;
			bucket_cfg = 7'(BUCKETS);
			fail_count = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				bucket_cfg = cfg_data;
			if (s_tvalid && s_tready)
				res_q.push_back(table_access(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (res_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					e = res_q.pop_front();
					if (m_tuser[0] !== e.found) begin
						$error("found: expected %0d actual %0d", e.found, m_tuser[0]);
						fail_count++;
					end
					if (m_tdata !== e.value_out) begin
						$error("value_out: expected %h actual %h", e.value_out, m_tdata);
						fail_count++;
					end
					if (m_tuser[1] !== e.inserted) begin
						$error("inserted: expected %0d actual %0d", e.inserted, m_tuser[1]);
						fail_count++;
					end
					if (m_tuser[2] !== e.full_res) begin
						$error("full_res: expected %0d actual %0d", e.full_res, m_tuser[2]);
						fail_count++;
					end
				end
			end
			pending = res_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: stimulus and verdict for chained_hash_map
// drives requests and bucket count writes; chm_scoreboard does the prediction
// depends on chm_pkg, chained_hash_map, chm_scoreboard
`timescale 1ns / 1ps

module tb_top import chm_pkg::*; ();

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;
	localparam int   WATCHDOG  = 20000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [63:0]      s_tdata = '0;
	logic [0:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [31:0]      m_tdata;
	logic [2:0]       m_tuser;
	int               fail_count;
	int               pending;
	int               results_seen;
	int               idle_cycles = 0;
	int               requests_sent = 0;
	int               gap_left = 0;
	logic [31:0]      used_keys[$];
	bit               stall_mode = 0;

	always #5 clk = ~clk;

	chained_hash_map dut (.*);

	chm_scoreboard chk (.*);

	// receiver stall pattern: alternate between free-running and choppy stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			stall_mode <= ~stall_mode;
		m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout with %0d results outstanding", pending);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [31:0] key, logic [31:0] val);
		if (gap_left == 0)
			gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
		else begin
			s_tvalid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
		if (op == OP_INSERT)
			used_keys.push_back(key);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			gap_left = $urandom_range(1, 6);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_buckets(logic [CFG_W-1:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4 && used_keys.size() > 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		if (sel < 7)
			return $urandom_range(0, 400) - 200;
		return $urandom;
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_cfg[6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd64};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge keys and values, lookup miss, duplicate insert
		send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);
		send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_INSERT, 32'h0, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_INSERT, 32'hFFFF_FFC0, 32'h1234_5678);
		send_request(OP_INSERT, 32'h0, 32'h5555_5555);
		send_request(OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_LOOKUP, 32'hFFFF_FFC0, 32'h0);
		send_request(OP_LOOKUP, 32'h40, 32'h0);
		// entries stay in their old chain after the bucket count changes
		write_buckets(7'd5);
		send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		send_request(OP_LOOKUP, 32'h0, 32'h0);
		send_request(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
		send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);

		// random phases over several bucket counts; the pool fills on the way
		for (int ph = 0; ph < 6; ph++) begin
			write_buckets(phase_cfg[ph]);
			for (int i = 0; i < 230; i++)
				send_request($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP,
					pick_key(), $urandom);
		end

		drain();
		$display("%0d requests and %0d results checked over bucket counts 0 to 127,",
			requests_sent, results_seen);
		$display("including a full pool, duplicate inserts and lookup misses");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
